### src/tuner_serial_command_receiver_defines.svh
// Assertion macros for the tuner serial command receiver
`ifndef TUNER_SERIAL_COMMAND_RECEIVER_DEFINES_SVH
`define TUNER_SERIAL_COMMAND_RECEIVER_DEFINES_SVH
// assert that a implies b on every clock edge out of reset
`define TSCR_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the next clock edge
`define TSCR_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### src/tscr_pkg.sv
// Package: types, constants and channel id table for the tuner receiver
`timescale 1ns / 1ps
package tscr_pkg;
  localparam int unsigned ChannelCountDefault = 62;
  localparam int unsigned IdTableLen = 62;

  typedef enum logic [2:0] {
    PH_STOP  = 3'd0,
    PH_DELAY = 3'd1,
    PH_START = 3'd2,
    PH_NEXT  = 3'd3,
    PH_ACK   = 3'd4,
    PH_READ  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    OP_SER_A = 3'd0,
    OP_SER_B = 3'd1,
    OP_WR_C  = 3'd2,
    OP_WR_D  = 3'd3,
    OP_RD_A  = 3'd4,
    OP_RD_B  = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_SCAN = 2'd1,
    SEQ_OUT  = 2'd2
  } seq_e;

  localparam logic [7:0] LineReset0 = 8'h67;
  localparam logic [7:0] LineReset1 = 8'hE7;
  localparam logic [7:0] CmdSet     = 8'hD8;
  localparam logic [7:0] CmdRead    = 8'hD9;
  localparam logic [7:0] CmdTune    = 8'hC0;
  localparam logic [7:0] TuneSkip   = 8'h86;
  localparam logic [7:0] SubFrame   = 8'h0D;
  localparam logic [7:0] SubAv      = 8'h02;
  localparam logic [7:0] AvOn       = 8'hE1;
  localparam logic [7:0] SubContr   = 8'h10;
  localparam logic [7:0] SubBright  = 8'h11;
  localparam logic [7:0] ReadDone   = 8'h40;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [5:0]  channel_index;
    logic        av_input_on;
    logic [7:0]  contrast_level;
    logic [7:0]  brightness_level;
    logic        frame_request;
  } result_t;

  function automatic logic [15:0] id_lookup(input logic [5:0] idx);
    logic [15:0] r;
    begin
      case (idx)
        6'd0:  r = 16'h0890; 6'd1:  r = 16'h08F0; 6'd2:  r = 16'h0950;
        6'd3:  r = 16'h0D90; 6'd4:  r = 16'h0DF0; 6'd5:  r = 16'h0E50;
        6'd6:  r = 16'h0EB0; 6'd7:  r = 16'h0EF0; 6'd8:  r = 16'h0F50;
        6'd9:  r = 16'h0FB0; 6'd10: r = 16'h1010; 6'd11: r = 16'h1070;
        6'd12: r = 16'h2050; 6'd13: r = 16'h20B0; 6'd14: r = 16'h2110;
        6'd15: r = 16'h2170; 6'd16: r = 16'h21D0; 6'd17: r = 16'h2230;
        6'd18: r = 16'h2290; 6'd19: r = 16'h22F0; 6'd20: r = 16'h2350;
        6'd21: r = 16'h23B0; 6'd22: r = 16'h2410; 6'd23: r = 16'h2470;
        6'd24: r = 16'h24D0; 6'd25: r = 16'h2530; 6'd26: r = 16'h2590;
        6'd27: r = 16'h25F0; 6'd28: r = 16'h2650; 6'd29: r = 16'h26B0;
        6'd30: r = 16'h2710; 6'd31: r = 16'h2770; 6'd32: r = 16'h27D0;
        6'd33: r = 16'h2830; 6'd34: r = 16'h2890; 6'd35: r = 16'h28F0;
        6'd36: r = 16'h2950; 6'd37: r = 16'h29B0; 6'd38: r = 16'h2A10;
        6'd39: r = 16'h2A70; 6'd40: r = 16'h2AD0; 6'd41: r = 16'h2B30;
        6'd42: r = 16'h2B90; 6'd43: r = 16'h2BF0; 6'd44: r = 16'h2C50;
        6'd45: r = 16'h2CB0; 6'd46: r = 16'h2D10; 6'd47: r = 16'h2D70;
        6'd48: r = 16'h2DD0; 6'd49: r = 16'h2E30; 6'd50: r = 16'h2E90;
        6'd51: r = 16'h2EF0; 6'd52: r = 16'h2F50; 6'd53: r = 16'h2FB0;
        6'd54: r = 16'h3010; 6'd55: r = 16'h3070; 6'd56: r = 16'h30D0;
        6'd57: r = 16'h3130; 6'd58: r = 16'h3190; 6'd59: r = 16'h31F0;
        6'd60: r = 16'h3250; 6'd61: r = 16'h32B0;
        default: r = 16'h0000;
      endcase
      return r;
    end
  endfunction
endpackage

### src/tscr_if.sv
// Valid/ready channel interfaces for command input and result output
`timescale 1ns / 1ps
interface tscr_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] value;
  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface tscr_res_if;
  logic                     valid;
  logic                     ready;
  tscr_pkg::result_t        payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/tscr_scan.sv
// Iterative channel id search: one table entry compared per cycle
`timescale 1ns / 1ps
`include "tuner_serial_command_receiver_defines.svh"
module tscr_scan #(
  parameter int unsigned ChannelCount = tscr_pkg::ChannelCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] id_i,
  output logic        busy_o,
  output logic        done_o,
  output logic        hit_o,
  output logic [5:0]  index_o
);
  localparam int unsigned Limit =
    (ChannelCount < tscr_pkg::IdTableLen) ? ChannelCount : tscr_pkg::IdTableLen;
  localparam logic [5:0] LastIdx = 6'(Limit - 1);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        hit_q, hit_d;
  logic [5:0]  idx_q, idx_d;
  logic [15:0] id_q, id_d;
  logic        match;

  assign match = (tscr_pkg::id_lookup(idx_q) == id_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    hit_d  = hit_q;
    idx_d  = idx_q;
    id_d   = id_q;
    if (start_i) begin
      busy_d = 1'b1;
      hit_d  = 1'b0;
      idx_d  = '0;
      id_d   = id_i;
    end else if (busy_q) begin
      if (match) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        hit_d  = 1'b1;
      end else if (idx_q == LastIdx) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      hit_q  <= hit_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign hit_o   = hit_q;
  assign index_o = idx_q;

  `TSCR_ASSERT_IMPL(a_scan_idx_range, clk_i, rst_ni, busy_q, idx_q <= LastIdx)
  `TSCR_ASSERT_NEXT(a_scan_done_ends, clk_i, rst_ni, busy_q && !start_i && (match || idx_q == LastIdx), done_q && !busy_q)
  `TSCR_ASSERT_IMPL(a_scan_done_idle, clk_i, rst_ni, done_q, !busy_q)
endmodule

### src/tuner_serial_command_receiver.sv
// Top level: serial link protocol, command decode and result register
// Latency: result valid the cycle after the input transfer. A C0 tune that
// completes adds the id search: one table entry compared per cycle, up to
// min(CHANNEL_COUNT, 62) entries compared when nothing matches.
// Throughput: one item at a time; input ready again once the result is taken.
// Reset (rst_ni, async low): stop phase, stream and command cleared, channel 1,
// all other registers zero.
`timescale 1ns / 1ps
`include "tuner_serial_command_receiver_defines.svh"
module tuner_serial_command_receiver #(
  parameter int unsigned CHANNEL_COUNT = tscr_pkg::ChannelCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  tscr_cmd_if.sink   in_i,
  tscr_res_if.source out_o
);
  tscr_pkg::phase_e ph_q, ph_d;
  tscr_pkg::seq_e   seq_q, seq_d;
  logic [5:0] tc_q, tc_d;
  logic [1:0] hb_q [4];
  logic [1:0] hb_d [4];
  logic [7:0] bs_q, bs_d;
  logic [7:0] cb_q [3];
  logic [7:0] cb_d [3];
  logic [2:0] cc_q, cc_d;
  logic       rp_q, rp_d;
  logic [5:0] ch_q, ch_d;
  logic       av_q, av_d;
  logic [7:0] con_q, con_d, bri_q, bri_d, sa_q, sa_d, sb_q, sb_d;
  logic [7:0] rd_q, rd_d;
  logic       fr_q, fr_d;
  logic       ovalid_q, ovalid_d;
  logic       scan_start;
  logic [15:0] scan_id;
  logic       scan_busy, scan_done, scan_hit;
  logic [5:0] scan_idx;
  logic       acc;

  assign acc = in_i.valid && in_i.ready;
  assign in_i.ready = (seq_q == tscr_pkg::SEQ_IDLE);

  tscr_scan #(.ChannelCount(CHANNEL_COUNT)) u_scan (
    .clk_i, .rst_ni,
    .start_i(scan_start), .id_i(scan_id),
    .busy_o(scan_busy), .done_o(scan_done), .hit_o(scan_hit), .index_o(scan_idx)
  );

  always_comb begin
    logic [7:0] v;
    logic [5:0] idx, cnt;
    logic       tune;
    logic [7:0] c0, p1, p2;
    logic       run;
    logic       clr;
    v = in_i.value;
    ph_d = ph_q; seq_d = seq_q; tc_d = tc_q; hb_d = hb_q; bs_d = bs_q;
    cb_d = cb_q; cc_d = cc_q; rp_d = rp_q; ch_d = ch_q; av_d = av_q;
    con_d = con_q; bri_d = bri_q; sa_d = sa_q; sb_d = sb_q;
    rd_d = rd_q; fr_d = fr_q; ovalid_d = ovalid_q;
    tune = 1'b0; scan_start = 1'b0; scan_id = '0;
    idx = tc_q; cnt = '0; run = 1'b0; clr = 1'b0;
    c0 = '0; p1 = '0; p2 = '0;
    case (seq_q)
      tscr_pkg::SEQ_IDLE: begin
        if (acc) begin
          rd_d = '0; fr_d = 1'b0;
          case (in_i.opcode)
            tscr_pkg::OP_SER_A, tscr_pkg::OP_SER_B: begin
              if (tc_q < 6'd63) tc_d = tc_q + 6'd1;
              if (idx < 6'd4) hb_d[idx[1:0]] = v[1:0];
              if (idx < 6'd32 && idx[1:0] == 2'd1) bs_d = {bs_q[6:0], v[0]};
              cnt = tc_d;
              if (v == tscr_pkg::LineReset0 || v == tscr_pkg::LineReset1) begin
                clr = 1'b1;
              end else if (ph_q == tscr_pkg::PH_STOP && cnt == 6'd3) begin
                if (hb_d[1] == 2'd3) begin
                  ph_d = hb_d[2][0] ? tscr_pkg::PH_DELAY : tscr_pkg::PH_START;
                  clr = 1'b1;
                end
              end else if (ph_q == tscr_pkg::PH_DELAY && cnt == 6'd1) begin
                if (!v[0]) ph_d = tscr_pkg::PH_START;
                clr = 1'b1;
              end else if (ph_q == tscr_pkg::PH_NEXT && cnt == 6'd3 && !rp_q) begin
                if (hb_d[1] == 2'd2) begin
                  // command runs in stop phase: D8 forms and C0 tune act here
                  if (cc_q == 3'd3 && cb_q[0] == tscr_pkg::CmdSet) begin
                    if (cb_q[1] == tscr_pkg::SubFrame && cb_q[2] == 8'h00) fr_d = 1'b1;
                    else if (cb_q[1] == tscr_pkg::SubAv)
                      av_d = (cb_q[2] == tscr_pkg::AvOn);
                    else if (cb_q[1] == tscr_pkg::SubContr) con_d = cb_q[2];
                    else if (cb_q[1] == tscr_pkg::SubBright) bri_d = cb_q[2];
                  end else if (cc_q == 3'd3 && cb_q[0] == tscr_pkg::CmdTune &&
                               cb_q[1] != tscr_pkg::TuneSkip) begin
                    tune = 1'b1;
                  end
                  ph_d = tscr_pkg::PH_STOP;
                  clr = 1'b1;
                  cc_d = '0; cb_d[0] = '0; cb_d[1] = '0; cb_d[2] = '0;
                  rp_d = 1'b0;
                end
              end else if (ph_q == tscr_pkg::PH_NEXT && cnt == 6'd4 && rp_q) begin
                if (hb_d[0] == 2'd1 && hb_d[1] == 2'd0 && hb_d[2] == 2'd2 &&
                    hb_d[3] == 2'd3) begin
                  ph_d = tscr_pkg::PH_STOP;
                  clr = 1'b1;
                  cc_d = '0; cb_d[0] = '0; cb_d[1] = '0; cb_d[2] = '0;
                  rp_d = 1'b0;
                end
              end else if ((ph_q == tscr_pkg::PH_START || ph_q == tscr_pkg::PH_NEXT) &&
                           cnt == 6'd32) begin
                ph_d = tscr_pkg::PH_ACK;
                clr = 1'b1;
                if (cc_q < 3'd3) cb_d[cc_q[1:0]] = bs_d;
                if (cc_q < 3'd4) cc_d = cc_q + 3'd1;
              end
              if (clr) begin
                tc_d = '0; hb_d[0] = '0; hb_d[1] = '0; hb_d[2] = '0; hb_d[3] = '0;
                bs_d = '0;
              end
              if (ph_d == tscr_pkg::PH_READ) begin
                if (tc_d == 6'd24) begin
                  ph_d = tscr_pkg::PH_ACK;
                  tc_d = '0; hb_d[0] = '0; hb_d[1] = '0; hb_d[2] = '0; hb_d[3] = '0;
                  bs_d = '0;
                  cc_d = '0; cb_d[0] = '0; cb_d[1] = '0; cb_d[2] = '0;
                  sa_d = sa_q | tscr_pkg::ReadDone;
                end
              end else if (ph_d == tscr_pkg::PH_ACK && tc_d == 6'd4) begin
                ph_d = tscr_pkg::PH_NEXT;
                tc_d = '0; hb_d[0] = '0; hb_d[1] = '0; hb_d[2] = '0; hb_d[3] = '0;
                bs_d = '0;
                c0 = cb_d[0]; p1 = cb_d[1]; p2 = cb_d[2];
                run = 1'b1;
                // command runs in next phase: D9 read or C0 tune
                if (cc_d == 3'd1 && c0 == tscr_pkg::CmdRead) begin
                  ph_d = tscr_pkg::PH_READ;
                  rp_d = 1'b1;
                end else if (cc_d == 3'd3 && c0 == tscr_pkg::CmdTune &&
                             p1 != tscr_pkg::TuneSkip) begin
                  tune = 1'b1;
                end
              end
              if (tune) begin
                scan_start = 1'b1;
                scan_id = run ? {p1, p2} : {cb_q[1], cb_q[2]};
              end
            end
            tscr_pkg::OP_WR_C: sa_d = v;
            tscr_pkg::OP_WR_D: sb_d = v;
            tscr_pkg::OP_RD_A: rd_d = sa_q;
            tscr_pkg::OP_RD_B: rd_d = sb_q;
            default: ;
          endcase
          if (tune) begin
            seq_d = tscr_pkg::SEQ_SCAN;
          end else begin
            seq_d = tscr_pkg::SEQ_OUT;
            ovalid_d = 1'b1;
          end
        end
      end
      tscr_pkg::SEQ_SCAN: begin
        if (scan_done) begin
          if (scan_hit) ch_d = scan_idx;
          seq_d = tscr_pkg::SEQ_OUT;
          ovalid_d = 1'b1;
        end
      end
      tscr_pkg::SEQ_OUT: begin
        if (out_o.ready) begin
          ovalid_d = 1'b0;
          seq_d = tscr_pkg::SEQ_IDLE;
        end
      end
      default: seq_d = tscr_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= tscr_pkg::PH_STOP; seq_q <= tscr_pkg::SEQ_IDLE;
      tc_q <= '0; bs_q <= '0; cc_q <= '0; rp_q <= 1'b0;
      for (int i = 0; i < 4; i++) hb_q[i] <= '0;
      for (int i = 0; i < 3; i++) cb_q[i] <= '0;
      ch_q <= 6'd1; av_q <= 1'b0; con_q <= '0; bri_q <= '0;
      sa_q <= '0; sb_q <= '0; ovalid_q <= 1'b0;
      rd_q <= '0; fr_q <= 1'b0;
    end else begin
      ph_q <= ph_d; seq_q <= seq_d; tc_q <= tc_d; bs_q <= bs_d;
      cc_q <= cc_d; rp_q <= rp_d; hb_q <= hb_d; cb_q <= cb_d;
      ch_q <= ch_d; av_q <= av_d; con_q <= con_d; bri_q <= bri_d;
      sa_q <= sa_d; sb_q <= sb_d; ovalid_q <= ovalid_d;
      rd_q <= rd_d; fr_q <= fr_d;
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.payload.read_data = rd_q;
  assign out_o.payload.channel_index = ch_q;
  assign out_o.payload.av_input_on = av_q;
  assign out_o.payload.contrast_level = con_q;
  assign out_o.payload.brightness_level = bri_q;
  assign out_o.payload.frame_request = fr_q;

  `TSCR_ASSERT_IMPL(a_valid_in_out, clk_i, rst_ni, ovalid_q, seq_q == tscr_pkg::SEQ_OUT)
  `TSCR_ASSERT_IMPL(a_scan_only_in_scan, clk_i, rst_ni, scan_busy, seq_q == tscr_pkg::SEQ_SCAN)
  `TSCR_ASSERT_IMPL(a_cc_sat, clk_i, rst_ni, 1'b1, cc_q <= 3'd4)
  `TSCR_ASSERT_IMPL(a_read_phase, clk_i, rst_ni, ph_q == tscr_pkg::PH_READ, rp_q)
endmodule
